@@ hdl/activation_function_unit_core_assert.svh @@
// Assertion macros for the activation function unit core.
`ifndef ACTIVATION_FUNCTION_UNIT_CORE_ASSERT_SVH
`define ACTIVATION_FUNCTION_UNIT_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AFU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/afu_pkg.sv @@
// Package for the activation function unit: constants, codes, stage record and math helpers.
`timescale 1ns / 1ps

package afu_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int EXP_SEGMENTS = 64;
    localparam int WQ           = 30;
    localparam int SEG_BITS     = $clog2(EXP_SEGMENTS);
    localparam int REM_BITS     = FRAC_BITS - SEG_BITS;
    localparam int REM_ENTRIES  = 2 ** REM_BITS;
    localparam int DATA_W       = 16;
    localparam int MAG_W        = DATA_W + 1;
    localparam int U_W          = MAG_W + 1;
    localparam int WHOLE_W      = U_W - FRAC_BITS;
    localparam int MAX_WHOLE    = 2 ** (U_W - 2 - FRAC_BITS);
    localparam int EW           = WQ + 1;
    localparam int DVS_W        = WQ + 2;
    localparam int NUM_W        = 2 * WQ + 1;
    localparam int XQ_W         = MAG_W + WQ - FRAC_BITS;
    localparam int COEF_W       = 15;
    localparam int OPA_W        = XQ_W;
    localparam int PROD_W       = OPA_W + EW;
    localparam int RMAG_W       = 40;
    localparam int Q_W          = RMAG_W + 1 - (WQ - FRAC_BITS);
    localparam int DIV_BITS     = 4;
    localparam int DIV_STAGES   = (EW + DIV_BITS - 1) / DIV_BITS;

    localparam int ST_IN        = 0;
    localparam int ST_LUT       = 1;
    localparam int ST_BASE      = 2;
    localparam int ST_POW       = 3;
    localparam int ST_DIVI      = ST_POW + MAX_WHOLE;
    localparam int ST_DIV       = ST_DIVI + 1;
    localparam int ST_MUL       = ST_DIV + DIV_STAGES;
    localparam int ST_SEL       = ST_MUL + 1;
    localparam int ST_SCL       = ST_SEL + 1;
    localparam int ST_RND       = ST_SCL + 1;
    localparam int NUM_STAGES   = ST_RND + 1;

    localparam logic [EW-1:0] ONE_W = EW'(1) << WQ;

    localparam logic [2:0] FN_SIGMOID = 3'd0;
    localparam logic [2:0] FN_TANH    = 3'd1;
    localparam logic [2:0] FN_RELU    = 3'd2;
    localparam logic [2:0] FN_ELU     = 3'd3;
    localparam logic [2:0] FN_SELU    = 3'd4;
    localparam logic [2:0] FN_LEAKY   = 3'd5;

    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_FUNC  = 3'd0;
    localparam logic [2:0] REG_DERIV = 3'd1;
    localparam logic [2:0] REG_ALPHA = 3'd2;
    localparam logic [2:0] REG_SCALE = 3'd3;
    localparam logic [2:0] REG_SLOPE = 3'd4;

    localparam logic [COEF_W-1:0] ALPHA_RST = COEF_W'(4096);
    localparam logic [COEF_W-1:0] SCALE_RST = COEF_W'(4304);
    localparam logic [COEF_W-1:0] SLOPE_RST = COEF_W'(41);

    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]         func;
        logic               deriv;
        logic               neg;
        logic               pos;
        logic [MAG_W-1:0]   mag;
        logic [WHOLE_W-1:0] whole;
        logic [EW-1:0]      ta;
        logic [EW-1:0]      tb;
        logic [EW-1:0]      e;
        logic [DVS_W-1:0]   dvs;
        logic [DVS_W-1:0]   prem;
        logic [EW-1:0]      nlo;
        logic [EW-1:0]      quo;
        logic [PROD_W-1:0]  prod;
        logic               rneg;
        logic [RMAG_W-1:0]  rmag;
        logic [DATA_W-1:0]  res;
        logic               clip;
    } item_t;

    // product of two values in [0,1], WQ fraction bits, rounded
    function automatic logic [EW-1:0] mul_w(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [2*EW-1:0] p;
        p = {{EW{1'b0}}, a} * {{EW{1'b0}}, b} + ((2*EW)'(1) << (WQ - 1));
        return p[WQ +: EW];
    endfunction

    // unsigned quotient by shift and subtract; constant tables only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-f for f in [0,1], series then reciprocal; used for constant tables only
    function automatic logic [EW-1:0] exp_piece(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        term = 64'(1) << WQ;
        sum  = 64'(1) << WQ;
        for (int k = 1; k <= 24; k++)
        begin
            term = udiv64(term * f, 64'(k) << WQ);
            sum  = sum + term;
        end
        q = udiv64((64'(1) << (2 * WQ)) + (sum >> 1), sum);
        return q[EW-1:0];
    endfunction

    localparam logic [EW-1:0] INV_E = exp_piece(64'(1) << WQ);

endpackage

@@ hdl/activation_function_unit_core.sv @@
// Activation function unit core: config registers and the full activation pipeline.
`timescale 1ns / 1ps

// Takes one signed Q4.12 sample per beat and returns one Q4.12 result per beat,
// rounded to nearest and saturated, with a clip flag. Throughput is one beat per
// cycle while out_ready is high. Sixteen e^-1 multiply stages handle the integer
// part of the exponent and eight radix-16 divide stages the sigmoid and tanh
// reciprocal. Registers (APB, byte address 4*i): func_select, derivative_mode,
// alpha, scale, leak_slope. Write them only while the pipeline is empty.
module activation_function_unit_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [afu_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [15:0]           sample_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [15:0]           sample_out,
    output logic                         clipped
);

    localparam int NS = afu_pkg::NUM_STAGES;
    localparam int EW = afu_pkg::EW;

    logic [2:0]                  func_select_reg;
    logic                        derivative_mode_reg;
    logic [afu_pkg::COEF_W-1:0]  alpha_coef_reg;
    logic [afu_pkg::COEF_W-1:0]  gain_coef_reg;
    logic [afu_pkg::COEF_W-1:0]  leak_slope_reg;
    logic                        wr_en;
    logic [2:0]                  reg_idx;

    afu_pkg::item_t pipe_reg  [NS];
    afu_pkg::item_t pipe_next [NS];
    logic [NS-1:0]  v_reg;
    logic [NS:0]    en;

    logic [EW-1:0] seg_tbl [afu_pkg::EXP_SEGMENTS];
    logic [EW-1:0] rem_tbl [afu_pkg::REM_ENTRIES];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[afu_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_select_reg     <= afu_pkg::FN_SIGMOID;
            derivative_mode_reg <= 1'b0;
            alpha_coef_reg      <= afu_pkg::ALPHA_RST;
            gain_coef_reg       <= afu_pkg::SCALE_RST;
            leak_slope_reg      <= afu_pkg::SLOPE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                afu_pkg::REG_FUNC:  func_select_reg     <= pwdata[2:0];
                afu_pkg::REG_DERIV: derivative_mode_reg <= pwdata[0];
                afu_pkg::REG_ALPHA: alpha_coef_reg      <= pwdata[afu_pkg::COEF_W-1:0];
                afu_pkg::REG_SCALE: gain_coef_reg       <= pwdata[afu_pkg::COEF_W-1:0];
                afu_pkg::REG_SLOPE: leak_slope_reg      <= pwdata[afu_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            afu_pkg::REG_FUNC:  prdata = 32'(func_select_reg);
            afu_pkg::REG_DERIV: prdata = 32'(derivative_mode_reg);
            afu_pkg::REG_ALPHA: prdata = 32'(alpha_coef_reg);
            afu_pkg::REG_SCALE: prdata = 32'(gain_coef_reg);
            afu_pkg::REG_SLOPE: prdata = 32'(leak_slope_reg);
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- exp tables ----------------
    for (genvar s = 0; s < afu_pkg::EXP_SEGMENTS; s++)
    begin : g_seg_tbl
        localparam logic [EW-1:0] SEG_VAL =
            afu_pkg::exp_piece(64'(s) << (afu_pkg::WQ - afu_pkg::SEG_BITS));
        assign seg_tbl[s] = SEG_VAL;
    end

    for (genvar t = 0; t < afu_pkg::REM_ENTRIES; t++)
    begin : g_rem_tbl
        localparam logic [EW-1:0] REM_VAL =
            afu_pkg::exp_piece(64'(t) << (afu_pkg::WQ - afu_pkg::FRAC_BITS));
        assign rem_tbl[t] = REM_VAL;
    end

    // ---------------- stage flow control ----------------
    always_comb
    begin
        en[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en[g])
            begin
                if (g == 0)
                begin
                    v_reg[g] <= in_valid;
                end
                else
                begin
                    v_reg[g] <= v_reg[(g == 0) ? 0 : g - 1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                pipe_reg[g] <= pipe_next[g];
            end
        end

        if (g == afu_pkg::ST_IN)
        begin : g_in
            always_comb
            begin
                pipe_next[g]       = '0;
                pipe_next[g].func  = func_select_reg;
                pipe_next[g].deriv = derivative_mode_reg;
                pipe_next[g].neg   = sample_in[15];
                pipe_next[g].mag   = sample_in[15]
                                     ? (afu_pkg::MAG_W'(1) << 16) - {1'b0, sample_in}
                                     : {1'b0, sample_in};
                pipe_next[g].pos   = !sample_in[15] && (sample_in != '0);
            end
        end
        else if (g == afu_pkg::ST_LUT)
        begin : g_lut
            logic [afu_pkg::U_W-1:0] u;
            always_comb
            begin
                pipe_next[g] = pipe_reg[g-1];
                u = (pipe_reg[g-1].func == afu_pkg::FN_TANH)
                    ? {pipe_reg[g-1].mag, 1'b0} : {1'b0, pipe_reg[g-1].mag};
                pipe_next[g].whole = u[afu_pkg::U_W-1:afu_pkg::FRAC_BITS];
                pipe_next[g].ta = seg_tbl[u[afu_pkg::FRAC_BITS-1:afu_pkg::REM_BITS]];
                pipe_next[g].tb = rem_tbl[u[afu_pkg::REM_BITS-1:0]];
            end
        end
        else if (g == afu_pkg::ST_BASE)
        begin : g_base
            always_comb
            begin
                pipe_next[g]   = pipe_reg[g-1];
                pipe_next[g].e = afu_pkg::mul_w(pipe_reg[g-1].ta, pipe_reg[g-1].tb);
            end
        end
        else if (g < afu_pkg::ST_DIVI)
        begin : g_pow
            always_comb
            begin
                pipe_next[g] = pipe_reg[g-1];
                if (pipe_reg[g-1].whole > afu_pkg::WHOLE_W'(g - afu_pkg::ST_POW))
                begin
                    pipe_next[g].e = afu_pkg::mul_w(pipe_reg[g-1].e, afu_pkg::INV_E);
                end
            end
        end
        else if (g == afu_pkg::ST_DIVI)
        begin : g_divi
            logic [afu_pkg::DVS_W-1:0] d;
            logic [afu_pkg::NUM_W-1:0] num;
            always_comb
            begin
                pipe_next[g] = pipe_reg[g-1];
                d = afu_pkg::DVS_W'(afu_pkg::ONE_W) + afu_pkg::DVS_W'(pipe_reg[g-1].e);
                if (pipe_reg[g-1].func == afu_pkg::FN_TANH && !pipe_reg[g-1].deriv)
                begin
                    num = (afu_pkg::NUM_W'(afu_pkg::ONE_W - pipe_reg[g-1].e) << afu_pkg::WQ)
                          + afu_pkg::NUM_W'(d >> 1);
                end
                else
                begin
                    num = (afu_pkg::NUM_W'(1) << (2 * afu_pkg::WQ)) + afu_pkg::NUM_W'(d >> 1);
                end
                pipe_next[g].dvs  = d;
                pipe_next[g].prem = afu_pkg::DVS_W'(num[afu_pkg::NUM_W-1:EW]);
                pipe_next[g].nlo  = num[EW-1:0];
                pipe_next[g].quo  = '0;
            end
        end
        else if (g < afu_pkg::ST_MUL)
        begin : g_div
            logic [afu_pkg::DVS_W-1:0] trial;
            logic [afu_pkg::DVS_W-1:0] r;
            logic [EW-1:0]             q;
            always_comb
            begin
                pipe_next[g] = pipe_reg[g-1];
                r = pipe_reg[g-1].prem;
                q = pipe_reg[g-1].quo;
                trial = '0;
                for (int t = 0; t < afu_pkg::DIV_BITS; t++)
                begin
                    if (EW - 1 - (g - afu_pkg::ST_DIV) * afu_pkg::DIV_BITS - t >= 0)
                    begin
                        trial = {r[afu_pkg::DVS_W-2:0],
                                 pipe_reg[g-1].nlo[EW - 1 - (g - afu_pkg::ST_DIV)
                                                   * afu_pkg::DIV_BITS - t]};
                        if (trial >= pipe_reg[g-1].dvs)
                        begin
                            r = trial - pipe_reg[g-1].dvs;
                            q[EW - 1 - (g - afu_pkg::ST_DIV) * afu_pkg::DIV_BITS - t] = 1'b1;
                        end
                        else
                        begin
                            r = trial;
                        end
                    end
                end
                pipe_next[g].prem = r;
                pipe_next[g].quo  = q;
            end
        end
        else if (g == afu_pkg::ST_MUL)
        begin : g_mul
            logic [afu_pkg::OPA_W-1:0] opa;
            logic [EW-1:0]             opb;
            afu_pkg::item_t            it;
            always_comb
            begin
                it  = pipe_reg[g-1];
                opa = '0;
                opb = '0;
                unique case (it.func)
                    afu_pkg::FN_SIGMOID, afu_pkg::FN_TANH:
                    begin
                        if (it.deriv)
                        begin
                            opa = afu_pkg::OPA_W'(it.quo);
                            opb = afu_pkg::ONE_W - it.quo;
                        end
                    end
                    afu_pkg::FN_ELU, afu_pkg::FN_SELU:
                    begin
                        opa = it.deriv ? afu_pkg::OPA_W'(it.e)
                                       : afu_pkg::OPA_W'(afu_pkg::ONE_W - it.e);
                        opb = EW'(alpha_coef_reg);
                    end
                    afu_pkg::FN_LEAKY:
                    begin
                        opa = afu_pkg::OPA_W'(it.mag) << (afu_pkg::WQ - afu_pkg::FRAC_BITS);
                        opb = EW'(leak_slope_reg);
                    end
                    default: ;
                endcase
                pipe_next[g]      = it;
                pipe_next[g].prod = afu_pkg::PROD_W'(opa) * afu_pkg::PROD_W'(opb);
            end
        end
        else if (g == afu_pkg::ST_SEL)
        begin : g_sel
            afu_pkg::item_t              it;
            logic [afu_pkg::RMAG_W-1:0]  xq;
            logic [afu_pkg::RMAG_W-1:0]  one;
            logic [afu_pkg::RMAG_W-1:0]  sc;
            logic [afu_pkg::PROD_W+1:0]  p4;
            always_comb
            begin
                it  = pipe_reg[g-1];
                xq  = afu_pkg::RMAG_W'(it.mag) << (afu_pkg::WQ - afu_pkg::FRAC_BITS);
                one = afu_pkg::RMAG_W'(afu_pkg::ONE_W);
                sc  = afu_pkg::RMAG_W'((it.prod + (afu_pkg::PROD_W'(1) << (afu_pkg::FRAC_BITS - 1)))
                                       >> afu_pkg::FRAC_BITS);
                p4  = {it.prod, 2'b00} + ((afu_pkg::PROD_W + 2)'(1) << (afu_pkg::WQ - 1));
                pipe_next[g]      = it;
                pipe_next[g].rneg = 1'b0;
                pipe_next[g].rmag = '0;
                unique case (it.func)
                    afu_pkg::FN_SIGMOID:
                    begin
                        if (it.deriv)
                            pipe_next[g].rmag = afu_pkg::RMAG_W'((it.prod
                                + (afu_pkg::PROD_W'(1) << (afu_pkg::WQ - 1))) >> afu_pkg::WQ);
                        else
                            pipe_next[g].rmag = it.neg ? afu_pkg::RMAG_W'(afu_pkg::ONE_W - it.quo)
                                                       : afu_pkg::RMAG_W'(it.quo);
                    end
                    afu_pkg::FN_TANH:
                    begin
                        if (it.deriv)
                        begin
                            pipe_next[g].rmag = afu_pkg::RMAG_W'(p4 >> afu_pkg::WQ);
                        end
                        else
                        begin
                            pipe_next[g].rmag = afu_pkg::RMAG_W'(it.quo);
                            pipe_next[g].rneg = it.neg;
                        end
                    end
                    afu_pkg::FN_RELU:
                    begin
                        if (it.deriv)
                            pipe_next[g].rmag = it.pos ? one : '0;
                        else
                            pipe_next[g].rmag = it.neg ? '0 : xq;
                    end
                    afu_pkg::FN_ELU, afu_pkg::FN_SELU:
                    begin
                        if (it.deriv)
                            pipe_next[g].rmag = it.pos ? one : (it.neg ? sc : '0);
                        else if (it.neg)
                        begin
                            pipe_next[g].rneg = 1'b1;
                            pipe_next[g].rmag = sc;
                        end
                        else
                            pipe_next[g].rmag = xq;
                    end
                    afu_pkg::FN_LEAKY:
                    begin
                        if (it.deriv)
                            pipe_next[g].rmag = it.pos ? one
                                : (it.neg ? afu_pkg::RMAG_W'(leak_slope_reg)
                                            << (afu_pkg::WQ - afu_pkg::FRAC_BITS) : '0);
                        else if (it.neg)
                        begin
                            pipe_next[g].rneg = 1'b1;
                            pipe_next[g].rmag = sc;
                        end
                        else
                            pipe_next[g].rmag = xq;
                    end
                    default: ;
                endcase
            end
        end
        else if (g == afu_pkg::ST_SCL)
        begin : g_scl
            logic [afu_pkg::RMAG_W+afu_pkg::COEF_W-1:0] sp;
            always_comb
            begin
                pipe_next[g] = pipe_reg[g-1];
                sp = (afu_pkg::RMAG_W + afu_pkg::COEF_W)'(pipe_reg[g-1].rmag)
                     * (afu_pkg::RMAG_W + afu_pkg::COEF_W)'(gain_coef_reg)
                     + ((afu_pkg::RMAG_W + afu_pkg::COEF_W)'(1) << (afu_pkg::FRAC_BITS - 1));
                if (pipe_reg[g-1].func == afu_pkg::FN_SELU)
                begin
                    pipe_next[g].rmag = afu_pkg::RMAG_W'(sp >> afu_pkg::FRAC_BITS);
                end
            end
        end
        else
        begin : g_rnd
            logic [afu_pkg::RMAG_W:0]  sum;
            logic [afu_pkg::Q_W-1:0]   q;
            always_comb
            begin
                pipe_next[g] = pipe_reg[g-1];
                sum = {1'b0, pipe_reg[g-1].rmag}
                      + ((afu_pkg::RMAG_W + 1)'(1) << (afu_pkg::WQ - afu_pkg::FRAC_BITS - 1));
                q = sum[afu_pkg::RMAG_W:afu_pkg::WQ - afu_pkg::FRAC_BITS];
                pipe_next[g].clip = 1'b0;
                if (pipe_reg[g-1].rneg)
                begin
                    if (q > afu_pkg::Q_W'(afu_pkg::NEG_MAX))
                    begin
                        pipe_next[g].res  = afu_pkg::NEG_MAX;
                        pipe_next[g].clip = 1'b1;
                    end
                    else
                    begin
                        pipe_next[g].res = afu_pkg::DATA_W'(0) - q[afu_pkg::DATA_W-1:0];
                    end
                end
                else
                begin
                    if (q > afu_pkg::Q_W'(afu_pkg::POS_MAX))
                    begin
                        pipe_next[g].res  = afu_pkg::POS_MAX;
                        pipe_next[g].clip = 1'b1;
                    end
                    else
                    begin
                        pipe_next[g].res = q[afu_pkg::DATA_W-1:0];
                    end
                end
            end
        end
    end

    assign out_valid  = v_reg[NS-1];
    assign sample_out = pipe_reg[NS-1].res;
    assign clipped    = pipe_reg[NS-1].clip;

    `include "activation_function_unit_core_assert.svh"

    `AFU_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "input stalled with empty output")
    `AFU_ASSERT_NOW(a_clip_at_rail, out_valid && clipped,
        sample_out == afu_pkg::POS_MAX || sample_out == afu_pkg::NEG_MAX, "clip off the rail")
    `AFU_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, v_reg[0], "accepted beat lost")

endmodule

@@ sim/activation_function_unit_core_test.sv @@
// Self-checking testbench for the activation function unit core.
`timescale 1ns / 1ps

module activation_function_unit_core_test;

    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;
    localparam longint unsigned UNIT = 64'd1 << 30;
    localparam int DRAIN_CYCLES = 48;

    typedef struct {
        logic [15:0] value;
        logic        clip;
    } act_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [afu_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [15:0]         sample_in;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [15:0]         sample_out;
    logic                       clipped;

    logic [2:0]  cur_func;
    logic        cur_deriv;
    logic [14:0] cur_alpha;
    logic [14:0] cur_scale;
    logic [14:0] cur_slope;

    act_result_t pending_results[$];
    int          error_count;
    int          burst_left;
    int          hold_cycles;
    int          stall_mode;
    int          mode_age;

    activation_function_unit_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // fixed-point math, 30 fraction bits
    function automatic longint unsigned unit_mul(longint unsigned a, longint unsigned b);
        return (a * b + (UNIT >> 1)) >> 30;
    endfunction

    function automatic longint unsigned exp_frac(longint unsigned f);
        longint unsigned term;
        longint unsigned total;
        term = UNIT;
        total = UNIT;
        for (int k = 1; k <= 24; k++)
        begin
            term = (term * f) / (longint'(k) << 30);
            total += term;
        end
        return ((UNIT << 30) + (total >> 1)) / total;
    endfunction

    function automatic longint unsigned exp_minus(longint unsigned u);
        longint unsigned whole;
        longint unsigned fq;
        longint unsigned seg;
        longint unsigned base;
        longint unsigned r;
        longint unsigned inv_e;
        whole = u >> afu_pkg::FRAC_BITS;
        fq = (u & 64'hFFF) << 18;
        seg = (fq * afu_pkg::EXP_SEGMENTS) >> 30;
        base = (seg << 30) / afu_pkg::EXP_SEGMENTS;
        r = unit_mul(exp_frac(base), exp_frac(fq - base));
        inv_e = exp_frac(UNIT);
        for (longint unsigned i = 0; i < whole && r != 0; i++)
            r = unit_mul(r, inv_e);
        return r;
    endfunction

    function automatic longint unsigned logistic(longint unsigned e);
        longint unsigned d;
        d = UNIT + e;
        return ((UNIT << 30) + (d >> 1)) / d;
    endfunction

    function automatic longint unsigned coef_mul(longint unsigned m, longint unsigned c);
        return (m * c + 64'd2048) >> afu_pkg::FRAC_BITS;
    endfunction

    function automatic act_result_t activate(logic [15:0] x);
        act_result_t     r;
        logic            neg;
        logic            pos;
        logic            rneg;
        longint unsigned mag;
        longint unsigned xq;
        longint unsigned rmag;
        longint unsigned sp;
        longint unsigned e;
        longint unsigned d;
        longint unsigned q;
        neg = x[15];
        mag = neg ? (64'h10000 - x) : x;
        pos = !neg && mag != 0;
        xq = mag << 18;
        rneg = 1'b0;
        rmag = 0;
        r.clip = 1'b0;
        case (cur_func)
            afu_pkg::FN_SIGMOID:
            begin
                sp = logistic(exp_minus(mag));
                if (cur_deriv)
                    rmag = unit_mul(sp, UNIT - sp);
                else
                    rmag = neg ? UNIT - sp : sp;
            end
            afu_pkg::FN_TANH:
            begin
                e = exp_minus(mag << 1);
                if (cur_deriv)
                begin
                    sp = logistic(e);
                    rmag = (4 * sp * (UNIT - sp) + (UNIT >> 1)) >> 30;
                end
                else
                begin
                    d = UNIT + e;
                    rmag = (((UNIT - e) << 30) + (d >> 1)) / d;
                    rneg = neg;
                end
            end
            afu_pkg::FN_RELU:
            begin
                if (cur_deriv)
                    rmag = pos ? UNIT : 0;
                else
                    rmag = neg ? 0 : xq;
            end
            afu_pkg::FN_ELU, afu_pkg::FN_SELU:
            begin
                if (cur_deriv)
                begin
                    if (pos)
                        rmag = UNIT;
                    else if (neg)
                        rmag = coef_mul(exp_minus(mag), cur_alpha);
                end
                else if (neg)
                begin
                    rneg = 1'b1;
                    rmag = coef_mul(UNIT - exp_minus(mag), cur_alpha);
                end
                else
                    rmag = xq;
                if (cur_func == afu_pkg::FN_SELU)
                    rmag = coef_mul(rmag, cur_scale);
            end
            afu_pkg::FN_LEAKY:
            begin
                if (cur_deriv)
                begin
                    if (pos)
                        rmag = UNIT;
                    else if (neg)
                        rmag = longint'(cur_slope) << 18;
                end
                else if (neg)
                begin
                    rneg = 1'b1;
                    rmag = coef_mul(xq, cur_slope);
                end
                else
                    rmag = xq;
            end
            default:
                rmag = 0;
        endcase
        q = (rmag + (64'd1 << 17)) >> 18;
        if (rneg)
        begin
            if (q > 64'h8000)
            begin
                q = 64'h8000;
                r.clip = 1'b1;
            end
            r.value = 16'(64'h10000 - q);
        end
        else
        begin
            if (q > 64'h7FFF)
            begin
                q = 64'h7FFF;
                r.clip = 1'b1;
            end
            r.value = q[15:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (error_count < 30)
            $display("%0t ns: %s got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // input capture and result check
    always @(posedge clk)
    begin
        act_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_results.push_back(activate(sample_in));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected beat", sample_out, 16'h0);
                else
                begin
                    want = pending_results.pop_front();
                    if (sample_out !== want.value)
                        report_mismatch("sample_out", sample_out, want.value);
                    if (clipped !== want.clip)
                        report_mismatch("clipped", 16'(clipped), 16'(want.clip));
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            if (mode_age == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_age <= $urandom_range(20, 90);
            end
            else
                mode_age <= mode_age - 1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= afu_pkg::ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            afu_pkg::REG_FUNC:  cur_func = val[2:0];
            afu_pkg::REG_DERIV: cur_deriv = val[0];
            afu_pkg::REG_ALPHA: cur_alpha = val[14:0];
            afu_pkg::REG_SCALE: cur_scale = val[14:0];
            afu_pkg::REG_SLOPE: cur_slope = val[14:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(logic [15:0] x);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sample_in <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_all(logic [2:0] fn, logic dv, logic [14:0] a, logic [14:0] s,
                           logic [14:0] l);
        reg_write(afu_pkg::REG_FUNC, 32'(fn));
        reg_write(afu_pkg::REG_DERIV, 32'(dv));
        reg_write(afu_pkg::REG_ALPHA, 32'(a));
        reg_write(afu_pkg::REG_SCALE, 32'(s));
        reg_write(afu_pkg::REG_SLOPE, 32'(l));
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 16383)) - 8192);
            2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($signed($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    function automatic logic [14:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 15'h0;
            1: return 15'h7FFF;
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    task automatic test_directed_extremes();
        logic [15:0] edge_vals[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                                      16'h8000, 16'h1000, 16'hF000, 16'h5555};
        foreach (edge_vals[i])
            send_sample(edge_vals[i]);
        drain();
        set_all(afu_pkg::FN_SELU, 1'b0, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hAAAA);
        drain();
        set_all(afu_pkg::FN_LEAKY, 1'b1, 15'h0, 15'h0, 15'h7FFF);
        send_sample(16'h0000);
        send_sample(16'h8000);
        send_sample(16'h0001);
        drain();
        set_all(FN_SPARE7, 1'b0, afu_pkg::ALPHA_RST, afu_pkg::SCALE_RST, afu_pkg::SLOPE_RST);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain();
    endtask

    task automatic test_every_function();
        logic [2:0] fns[8] = '{afu_pkg::FN_SIGMOID, afu_pkg::FN_TANH, afu_pkg::FN_RELU,
                               afu_pkg::FN_ELU, afu_pkg::FN_SELU, afu_pkg::FN_LEAKY,
                               FN_SPARE6, FN_SPARE7};
        foreach (fns[i])
            for (int dv = 0; dv < 2; dv++)
            begin
                set_all(fns[i], dv[0], rand_coef(), rand_coef(), rand_coef());
                send_sample(16'h0000);
                repeat (22) send_sample(rand_sample());
                drain();
            end
    endtask

    task automatic test_backpressure();
        set_all(afu_pkg::FN_TANH, 1'b0, afu_pkg::ALPHA_RST, afu_pkg::SCALE_RST,
                afu_pkg::SLOPE_RST);
        @(negedge clk);
        hold_cycles = 200;
        repeat (80) send_sample(rand_sample());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        sample_in = '0;
        out_ready = 1'b0;
        cur_func = afu_pkg::FN_SIGMOID;
        cur_deriv = 1'b0;
        cur_alpha = afu_pkg::ALPHA_RST;
        cur_scale = afu_pkg::SCALE_RST;
        cur_slope = afu_pkg::SLOPE_RST;
        error_count = 0;
        burst_left = 0;
        hold_cycles = 0;
        stall_mode = 0;
        mode_age = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_extremes();
        test_every_function();
        test_backpressure();
        if (pending_results.size() != 0)
            report_mismatch("results missing", 16'(pending_results.size()), 16'h0);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
